### design/riff_wave_header_validator_assert.svh
// ----------------------------------------------------------------------------
// RIFF/WAVE header validator assertion macros
// Shared concurrent assertion forms, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RIFF_WAVE_HEADER_VALIDATOR_ASSERT_SVH
`define RIFF_WAVE_HEADER_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define RWHV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RWHV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rwhv_pkg.sv
// ----------------------------------------------------------------------------
// rwhv_pkg
// Types, tags and limits shared by the RIFF/WAVE header validator.
// ----------------------------------------------------------------------------
`default_nettype none

package rwhv_pkg;

	localparam int CntW   = 34;
	localparam int LenW   = 33;
	localparam int WordW  = 32;
	localparam int HalfW  = 16;
	localparam int ProdW  = WordW + HalfW;
	localparam int DivBits = WordW;
	localparam int DivCntW = $clog2(DivBits);

	localparam logic [CntW-1:0]  CNT_MAX     = {CntW{1'b1}};
	localparam logic [CntW-1:0]  MIN_FILE    = 34'd48;
	localparam logic [CntW-1:0]  POS_RIFF    = 34'd3;
	localparam logic [CntW-1:0]  POS_LEN     = 34'd7;
	localparam logic [CntW-1:0]  POS_WAVE    = 34'd11;
	localparam logic [CntW-1:0]  FIRST_CHUNK = 34'd12;
	localparam logic [LenW-1:0]  LEN_ADJ     = 33'd8;

	localparam logic [WordW-1:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [WordW-1:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [WordW-1:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [WordW-1:0] TAG_DATA = 32'h6174_6164;

	localparam logic [WordW-1:0] RATE_MIN = 32'd8000;
	localparam logic [WordW-1:0] RATE_MAX = 32'd192000;
	localparam logic [WordW-1:0] FMT_MIN  = 32'd16;

	localparam logic [HalfW-1:0] FMT_PCM   = 16'd1;
	localparam logic [HalfW-1:0] CH_MONO   = 16'd1;
	localparam logic [HalfW-1:0] CH_STEREO = 16'd2;
	localparam logic [HalfW-1:0] BITS_8    = 16'd8;
	localparam logic [HalfW-1:0] BITS_16   = 16'd16;

	// byte offsets inside a chunk header and a fmt body
	localparam logic [2:0] HDR_OFF_ID   = 3'd3;
	localparam logic [2:0] HDR_OFF_SIZE = 3'd7;
	localparam logic [3:0] FMT_OFF_TAG   = 4'd1;
	localparam logic [3:0] FMT_OFF_CHAN  = 4'd3;
	localparam logic [3:0] FMT_OFF_RATE  = 4'd7;
	localparam logic [3:0] FMT_OFF_BRATE = 4'd11;
	localparam logic [3:0] FMT_OFF_ALIGN = 4'd13;
	localparam logic [3:0] FMT_OFF_BITS  = 4'd15;

	typedef enum logic [6:0] {
		PH_RIFF = 7'b000_0001,
		PH_LEN  = 7'b000_0010,
		PH_WAVE = 7'b000_0100,
		PH_SEEK = 7'b000_1000,
		PH_HDR  = 7'b001_0000,
		PH_FMT  = 7'b010_0000,
		PH_DONE = 7'b100_0000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_FMT   = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		FLT_NONE      = 4'd0,
		FLT_SHORT     = 4'd1,
		FLT_RIFF      = 4'd2,
		FLT_WAVE      = 4'd3,
		FLT_LENGTH    = 4'd4,
		FLT_OVERRUN   = 4'd5,
		FLT_SMALL_FMT = 4'd6,
		FLT_FORMAT    = 4'd7,
		FLT_DATA      = 4'd8
	} fault_t;

	typedef struct packed {
		logic accept;
		logic finalize;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_start;
		logic div_done;
		logic last_accept;
		logic slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

### design/rwhv_mod.sv
// ----------------------------------------------------------------------------
// rwhv_mod
// Restoring remainder unit, one dividend bit per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhv_mod
	import rwhv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WordW-1:0] dividend,
	input  wire logic [HalfW-1:0] divisor,
	output logic                  done,
	output logic                  zero_rem
);

	logic               busy_q;
	logic [DivCntW-1:0] cnt_q;
	logic [WordW-1:0]   dvd_q;
	logic [HalfW-1:0]   den_q;
	logic [HalfW-1:0]   rem_q;

	logic [HalfW:0]   rem_sh;
	logic [HalfW:0]   diff;
	logic             ge;
	logic [HalfW-1:0] rem_nxt;

	assign rem_sh  = {rem_q, dvd_q[WordW-1]};
	assign diff    = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};
	// remainder stays below the divisor, so the top bit is free either way
	assign rem_nxt = ge ? diff[HalfW-1:0] : rem_sh[HalfW-1:0];

	assign done     = busy_q && (cnt_q == DivCntW'(DivBits - 1));
	assign zero_rem = rem_nxt == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WordW-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

endmodule

`default_nettype wire

### design/rwhv_ctrl.sv
// ----------------------------------------------------------------------------
// rwhv_ctrl
// Sequencer: takes bytes, waits out the remainder unit, posts the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhv_ctrl
	import rwhv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_RUN = 3'b001,
		ST_DIV = 3'b010,
		ST_FIN = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   last_pend_q, last_pend_d;

	assign item_stall   = state_q != ST_RUN;
	assign cmd.accept   = item_valid && (state_q == ST_RUN);
	assign cmd.finalize = (state_q == ST_FIN) && status.slot_free;

	always_comb begin
		state_d     = state_q;
		last_pend_d = last_pend_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.accept) begin
					if (status.div_start) begin
						state_d     = ST_DIV;
						last_pend_d = status.last_accept;
					end else if (status.last_accept) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d     = last_pend_q ? ST_FIN : ST_RUN;
					last_pend_d = 1'b0;
				end
			end
			ST_FIN: begin
				if (cmd.finalize) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d     = ST_RUN;
				last_pend_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			last_pend_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			last_pend_q <= last_pend_d;
		end
	end

endmodule

`default_nettype wire

### design/rwhv_dp.sv
// ----------------------------------------------------------------------------
// rwhv_dp
// Byte parser, chunk walker, fmt field capture, checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwhv_dp
	import rwhv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire ctrl_cmd_t        cmd,
	output dp_status_t            status,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic                  valid_res,
	output logic [3:0]            fault,
	output logic [HalfW-1:0]      channels,
	output logic [WordW-1:0]      rate_hz,
	output logic [HalfW-1:0]      bits_per_sample,
	output logic [HalfW-1:0]      block_align
);

	function automatic logic fmt_check(
		input logic [HalfW-1:0] wf,
		input logic [HalfW-1:0] ch,
		input logic [WordW-1:0] rate,
		input logic [WordW-1:0] brate,
		input logic [HalfW-1:0] al,
		input logic [HalfW-1:0] bits,
		input logic [ProdW-1:0] prod
	);
		logic [HalfW-1:0] base;
		logic [HalfW-1:0] exp_al;
		logic             ok;
		base   = (bits == BITS_16) ? 16'd2 : 16'd1;
		exp_al = (ch == CH_STEREO) ? {base[HalfW-2:0], 1'b0} : base;
		ok = (wf == FMT_PCM) && (ch == CH_MONO || ch == CH_STEREO)
			&& (rate >= RATE_MIN) && (rate <= RATE_MAX)
			&& (bits == BITS_8 || bits == BITS_16)
			&& (al == exp_al) && (prod == {{HalfW{1'b0}}, brate});
		return ok;
	endfunction

	// parse state
	logic [CntW-1:0]  cnt_q, cnt_d;
	logic [LenW-1:0]  rlen_q, rlen_d;
	phase_t           phase_q, phase_d;
	logic [WordW-1:0] wa_q, wa_d;
	kind_t            kind_q, kind_d;
	logic [WordW-1:0] size_q, size_d;
	logic [CntW-1:0]  cend_q, cend_d;
	logic [2:0]       hoff_q, hoff_d;
	logic [3:0]       foff_q, foff_d;
	logic [HalfW-1:0] wfmt_q, wfmt_d;
	logic [HalfW-1:0] chan_q, chan_d;
	logic [WordW-1:0] rate_q, rate_d;
	logic [WordW-1:0] brate_q, brate_d;
	logic [HalfW-1:0] align_q, align_d;
	logic [HalfW-1:0] bits_q, bits_d;
	logic             fmt_ok_q, fmt_ok_d;
	logic             data_ok_q, data_ok_d;
	fault_t           fault_q, fault_d;
	logic [ProdW-1:0] prod_q;

	// result register
	logic             res_valid_q;
	logic             res_ok_q;
	fault_t           res_fault_q;
	logic [HalfW-1:0] res_chan_q;
	logic [WordW-1:0] res_rate_q;
	logic [HalfW-1:0] res_bits_q;
	logic [HalfW-1:0] res_align_q;

	logic [CntW-1:0]  p;
	logic [WordW-1:0] wa_n;
	logic             hdr_enter;
	logic             fits;
	logic [CntW:0]    next_end;
	phase_t           eff_phase;
	logic [2:0]       eff_hoff;
	logic             div_start;
	logic             div_done;
	logic             zero_rem;
	fault_t           fin_fault;
	logic             early;
	logic [ProdW-1:0] prod_c;

	assign p         = cnt_q;
	assign wa_n      = {data_byte, wa_q[WordW-1:8]};
	assign hdr_enter = (phase_q == PH_SEEK) && (p == cend_q);
	assign fits      = ({1'b0, p} + 35'd8) <= {2'b00, rlen_q};
	assign next_end  = {1'b0, p} + 35'd1 + {3'b000, wa_n};
	assign eff_phase = hdr_enter ? (fits ? PH_HDR : PH_DONE) : phase_q;
	assign eff_hoff  = hdr_enter ? 3'd0 : hoff_q;
	assign prod_c    = rate_q * align_q;

	always_comb begin
		cnt_d     = cnt_q;
		rlen_d    = rlen_q;
		phase_d   = phase_q;
		wa_d      = wa_q;
		kind_d    = kind_q;
		size_d    = size_q;
		cend_d    = cend_q;
		hoff_d    = hoff_q;
		foff_d    = foff_q;
		wfmt_d    = wfmt_q;
		chan_d    = chan_q;
		rate_d    = rate_q;
		brate_d   = brate_q;
		align_d   = align_q;
		bits_d    = bits_q;
		fmt_ok_d  = fmt_ok_q;
		data_ok_d = data_ok_q;
		fault_d   = fault_q;
		div_start = 1'b0;
		if (cmd.accept) begin
			cnt_d   = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
			wa_d    = wa_n;
			phase_d = eff_phase;
			case (eff_phase)
				PH_RIFF: begin
					if (p == POS_RIFF) begin
						if (wa_n != TAG_RIFF) begin
							fault_d = FLT_RIFF;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (p == POS_LEN) begin
						rlen_d  = {1'b0, wa_n} + LEN_ADJ;
						phase_d = PH_WAVE;
					end
				end
				PH_WAVE: begin
					if (p == POS_WAVE) begin
						if (wa_n != TAG_WAVE) begin
							fault_d = FLT_WAVE;
							phase_d = PH_DONE;
						end else begin
							cend_d  = FIRST_CHUNK;
							phase_d = PH_SEEK;
						end
					end
				end
				PH_HDR: begin
					hoff_d = eff_hoff + 1'b1;
					if (eff_hoff == HDR_OFF_ID) begin
						kind_d = (wa_n == TAG_FMT) ? KIND_FMT :
							(wa_n == TAG_DATA) ? KIND_DATA : KIND_OTHER;
					end else if (eff_hoff == HDR_OFF_SIZE) begin
						size_d = wa_n;
						if (next_end > {2'b00, rlen_q}) begin
							fault_d = FLT_OVERRUN;
							phase_d = PH_DONE;
						end else if (kind_q == KIND_FMT) begin
							if (wa_n < FMT_MIN) begin
								fault_d = FLT_SMALL_FMT;
								phase_d = PH_DONE;
							end else begin
								cend_d  = next_end[CntW-1:0];
								foff_d  = '0;
								phase_d = PH_FMT;
							end
						end else begin
							if (kind_q == KIND_DATA) begin
								// zero size or no alignment fails without dividing
								if (wa_n != '0 && align_q != '0) begin
									div_start = 1'b1;
								end else begin
									data_ok_d = 1'b0;
								end
							end
							cend_d  = next_end[CntW-1:0] + {{(CntW-1){1'b0}}, wa_n[0]};
							phase_d = PH_SEEK;
						end
					end
				end
				PH_FMT: begin
					foff_d = foff_q + 1'b1;
					case (foff_q)
						FMT_OFF_TAG:   wfmt_d  = wa_n[WordW-1:HalfW];
						FMT_OFF_CHAN:  chan_d  = wa_n[WordW-1:HalfW];
						FMT_OFF_RATE:  rate_d  = wa_n;
						FMT_OFF_BRATE: brate_d = wa_n;
						FMT_OFF_ALIGN: align_d = wa_n[WordW-1:HalfW];
						FMT_OFF_BITS: begin
							bits_d   = wa_n[WordW-1:HalfW];
							fmt_ok_d = fmt_check(wfmt_q, chan_q, rate_q, brate_q,
								align_q, wa_n[WordW-1:HalfW], prod_q);
							cend_d   = cend_q + {{(CntW-1){1'b0}}, size_q[0]};
							phase_d  = PH_SEEK;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (div_done) begin
			data_ok_d = zero_rem;
		end
	end

	// final verdict, in priority order
	always_comb begin
		if (cnt_q < MIN_FILE) begin
			fin_fault = FLT_SHORT;
		end else if (fault_q == FLT_RIFF || fault_q == FLT_WAVE) begin
			fin_fault = fault_q;
		end else if ({1'b0, rlen_q} > cnt_q) begin
			fin_fault = FLT_LENGTH;
		end else if (fault_q != FLT_NONE) begin
			fin_fault = fault_q;
		end else if (!fmt_ok_q) begin
			fin_fault = FLT_FORMAT;
		end else if (!data_ok_q) begin
			fin_fault = FLT_DATA;
		end else begin
			fin_fault = FLT_NONE;
		end
	end

	assign early = (fin_fault == FLT_SHORT) || (fin_fault == FLT_RIFF)
		|| (fin_fault == FLT_WAVE) || (fin_fault == FLT_LENGTH);

	rwhv_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wa_n),
		.divisor  (align_q),
		.done     (div_done),
		.zero_rem (zero_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rlen_q    <= '0;
			phase_q   <= PH_RIFF;
			wa_q      <= '0;
			kind_q    <= KIND_OTHER;
			size_q    <= '0;
			cend_q    <= '0;
			hoff_q    <= '0;
			foff_q    <= '0;
			wfmt_q    <= '0;
			chan_q    <= '0;
			rate_q    <= '0;
			brate_q   <= '0;
			align_q   <= '0;
			bits_q    <= '0;
			fmt_ok_q  <= 1'b0;
			data_ok_q <= 1'b0;
			fault_q   <= FLT_NONE;
		end else if (cmd.finalize) begin
			// back to the reset state for the next file
			cnt_q     <= '0;
			rlen_q    <= '0;
			phase_q   <= PH_RIFF;
			wa_q      <= '0;
			kind_q    <= KIND_OTHER;
			size_q    <= '0;
			cend_q    <= '0;
			hoff_q    <= '0;
			foff_q    <= '0;
			wfmt_q    <= '0;
			chan_q    <= '0;
			rate_q    <= '0;
			brate_q   <= '0;
			align_q   <= '0;
			bits_q    <= '0;
			fmt_ok_q  <= 1'b0;
			data_ok_q <= 1'b0;
			fault_q   <= FLT_NONE;
		end else begin
			cnt_q     <= cnt_d;
			rlen_q    <= rlen_d;
			phase_q   <= phase_d;
			wa_q      <= wa_d;
			kind_q    <= kind_d;
			size_q    <= size_d;
			cend_q    <= cend_d;
			hoff_q    <= hoff_d;
			foff_q    <= foff_d;
			wfmt_q    <= wfmt_d;
			chan_q    <= chan_d;
			rate_q    <= rate_d;
			brate_q   <= brate_d;
			align_q   <= align_d;
			bits_q    <= bits_d;
			fmt_ok_q  <= fmt_ok_d;
			data_ok_q <= data_ok_d;
			fault_q   <= fault_d;
		end
	end

	// rate and alignment settle two bytes before the last fmt field
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finalize) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finalize) begin
			res_ok_q    <= fin_fault == FLT_NONE;
			res_fault_q <= fin_fault;
			res_chan_q  <= early ? '0 : chan_q;
			res_rate_q  <= early ? '0 : rate_q;
			res_bits_q  <= early ? '0 : bits_q;
			res_align_q <= early ? '0 : align_q;
		end
	end

	assign status.div_start   = div_start;
	assign status.div_done    = div_done;
	assign status.last_accept = cmd.accept && last_byte;
	assign status.slot_free   = !res_valid_q || !result_stall;

	assign result_valid    = res_valid_q;
	assign valid_res       = res_ok_q;
	assign fault           = res_fault_q;
	assign channels        = res_chan_q;
	assign rate_hz         = res_rate_q;
	assign bits_per_sample = res_bits_q;
	assign block_align     = res_align_q;

endmodule

`default_nettype wire

### design/riff_wave_header_validator.sv
// ----------------------------------------------------------------------------
// riff_wave_header_validator
// Streaming RIFF/WAVE PCM header checker with one verdict per file.
// ----------------------------------------------------------------------------
// Feed the file one byte per item, last_byte set on its final byte; one result
// item follows each file. A byte is taken every cycle, except that after the
// size field of a data chunk whose size and current block alignment are both
// non-zero the input stalls while the bit-serial remainder unit checks the size
// against the alignment. After the final byte the input stalls, the sequencer
// enters its finish state (once the remainder check is over, if the final byte
// started one) and, when the result slot is free, the verdict is registered and
// posted; the next file's bytes may then stream in while that result waits to
// be taken. No clearing pass follows reset.
`default_nettype none

module riff_wave_header_validator
	import rwhv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic                  valid_res,
	output logic [3:0]            fault,
	output logic [HalfW-1:0]      channels,
	output logic [WordW-1:0]      rate_hz,
	output logic [HalfW-1:0]      bits_per_sample,
	output logic [HalfW-1:0]      block_align
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rwhv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	rwhv_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.cmd             (cmd),
		.status          (status),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.valid_res       (valid_res),
		.fault           (fault),
		.channels        (channels),
		.rate_hz         (rate_hz),
		.bits_per_sample (bits_per_sample),
		.block_align     (block_align)
	);

endmodule

`default_nettype wire

### design/rwhv_checker.sv
// ----------------------------------------------------------------------------
// rwhv_checker
// Port-level checks on the validator's result channel and input stall, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "riff_wave_header_validator_assert.svh"

module rwhv_checker
	import rwhv_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire logic             last_byte,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire logic             valid_res,
	input wire logic [3:0]       fault,
	input wire logic [HalfW-1:0] channels,
	input wire logic [WordW-1:0] rate_hz,
	input wire logic [HalfW-1:0] bits_per_sample,
	input wire logic [HalfW-1:0] block_align
);

	logic                       is_pass;
	logic                       early_f;
	logic                       fields_zero;
	logic                       pcm_ok;
	logic                       last_take;
	logic [3*HalfW+WordW+4:0]   res_word;

	assign is_pass     = fault == FLT_NONE;
	assign early_f     = result_valid && (fault >= FLT_SHORT) && (fault <= FLT_LENGTH);
	assign fields_zero = (channels == '0) && (rate_hz == '0)
		&& (bits_per_sample == '0) && (block_align == '0);
	assign pcm_ok      = (channels == CH_MONO || channels == CH_STEREO)
		&& (bits_per_sample == BITS_8 || bits_per_sample == BITS_16)
		&& (rate_hz >= RATE_MIN) && (rate_hz <= RATE_MAX);
	assign last_take   = item_valid && !item_stall && last_byte;
	assign res_word    = {valid_res, fault, channels, rate_hz, bits_per_sample, block_align};

	`RWHV_ASSERT_IMP(a_pass_flag, result_valid, valid_res == is_pass, "valid_res vs fault")
	`RWHV_ASSERT_IMP(a_early_zero, early_f, fields_zero, "fmt fields set on header fault")
	`RWHV_ASSERT_IMP(a_pass_pcm, result_valid && valid_res, pcm_ok, "passed non-PCM format")
	`RWHV_ASSERT_NXT(a_res_hold, result_valid && result_stall, result_valid && $stable(res_word), "stalled result moved")
	`RWHV_ASSERT_NXT(a_last_stall, last_take, item_stall, "byte taken right after a last byte")

endmodule

bind riff_wave_header_validator rwhv_checker u_rwhv_checker (.*);

`default_nettype wire

### tb/wave_verdict_pkg.sv
// ----------------------------------------------------------------------------
// wave_verdict_pkg
// Scoreboard for the RIFF/WAVE header validator. It parses the byte stream
// the same way the block does and keeps the verdicts still owed, in order.
// ----------------------------------------------------------------------------
package wave_verdict_pkg;
	import rwhv_pkg::*;

	typedef struct {
		logic             ok;
		fault_t           code;
		logic [HalfW-1:0] chans;
		logic [WordW-1:0] rate;
		logic [HalfW-1:0] bits;
		logic [HalfW-1:0] align;
	} verdict_t;

	class wave_verdict_board;
		int unsigned errors;
		verdict_t    verdicts_due[$];

		// parse state of the file in flight
		logic [CntW-1:0]  seen;
		logic [LenW-1:0]  declared_end;
		phase_t           phase;
		logic [WordW-1:0] shift_word;
		kind_t            kind;
		logic [WordW-1:0] size_word;
		logic [CntW-1:0]  mark;
		logic [HalfW-1:0] fmt_tag, fmt_chans, fmt_align, fmt_bits;
		logic [WordW-1:0] fmt_rate, fmt_brate;
		logic             fmt_good, data_good;
		fault_t           flt;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			seen = '0;
			declared_end = '0;
			phase = PH_RIFF;
			shift_word = '0;
			kind = KIND_OTHER;
			size_word = '0;
			mark = '0;
			fmt_tag = '0;
			fmt_chans = '0;
			fmt_align = '0;
			fmt_bits = '0;
			fmt_rate = '0;
			fmt_brate = '0;
			fmt_good = 1'b0;
			data_good = 1'b0;
			flt = FLT_NONE;
		endfunction

		function void halt_walk(fault_t code);
			flt = code;
			phase = PH_DONE;
		endfunction

		function logic format_passes();
			logic [WordW-1:0] want_align;
			want_align = 32'(fmt_chans) * 32'(fmt_bits) / 8;
			if (fmt_tag != FMT_PCM)
				return 1'b0;
			if (fmt_chans != CH_MONO && fmt_chans != CH_STEREO)
				return 1'b0;
			if (fmt_rate < RATE_MIN || fmt_rate > RATE_MAX)
				return 1'b0;
			if (fmt_bits != BITS_8 && fmt_bits != BITS_16)
				return 1'b0;
			if (32'(fmt_align) != want_align)
				return 1'b0;
			return fmt_brate == fmt_rate * 32'(fmt_align);
		endfunction

		// size field of a chunk header just completed at byte p
		function void close_header(longint unsigned p);
			longint unsigned nxt;
			nxt = p + 1 + 64'(size_word);
			if (nxt > 64'(declared_end))
				halt_walk(FLT_OVERRUN);
			else if (kind == KIND_FMT) begin
				if (size_word < FMT_MIN)
					halt_walk(FLT_SMALL_FMT);
				else begin
					mark = CntW'(nxt);
					phase = PH_FMT;
				end
			end else begin
				if (kind == KIND_DATA)
					data_good = size_word != 0 && fmt_align != 0 &&
						size_word % 32'(fmt_align) == 0;
				mark = CntW'(nxt + 64'(size_word[0]));
				phase = PH_SEEK;
			end
		endfunction

		function void take_fmt_byte(longint unsigned off);
			case (off)
				FMT_OFF_TAG:   fmt_tag = shift_word[WordW-1:HalfW];
				FMT_OFF_CHAN:  fmt_chans = shift_word[WordW-1:HalfW];
				FMT_OFF_RATE:  fmt_rate = shift_word;
				FMT_OFF_BRATE: fmt_brate = shift_word;
				FMT_OFF_ALIGN: fmt_align = shift_word[WordW-1:HalfW];
				FMT_OFF_BITS: begin
					fmt_bits = shift_word[WordW-1:HalfW];
					fmt_good = format_passes();
					// mark sits at the body end; skip the pad byte too
					mark = mark + size_word[0];
					phase = PH_SEEK;
				end
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			longint unsigned p, off;
			verdict_t v;
			logic early;
			p = 64'(seen);
			if (seen != CNT_MAX)
				seen = seen + 1'b1;
			shift_word = {b, shift_word[WordW-1:8]};
			if (phase == PH_SEEK && p == 64'(mark)) begin
				if (p + 8 <= 64'(declared_end)) begin
					phase = PH_HDR;
					mark = CntW'(p);
				end else
					phase = PH_DONE;
			end
			case (phase)
				PH_RIFF: if (p == 64'(POS_RIFF)) begin
					if (shift_word != TAG_RIFF)
						halt_walk(FLT_RIFF);
					else
						phase = PH_LEN;
				end
				PH_LEN: if (p == 64'(POS_LEN)) begin
					declared_end = {1'b0, shift_word} + LEN_ADJ;
					phase = PH_WAVE;
				end
				PH_WAVE: if (p == 64'(POS_WAVE)) begin
					if (shift_word != TAG_WAVE)
						halt_walk(FLT_WAVE);
					else begin
						mark = FIRST_CHUNK;
						phase = PH_SEEK;
					end
				end
				PH_HDR: begin
					off = p - 64'(mark);
					if (off == HDR_OFF_ID)
						kind = (shift_word == TAG_FMT) ? KIND_FMT :
							(shift_word == TAG_DATA) ? KIND_DATA : KIND_OTHER;
					else if (off == HDR_OFF_SIZE) begin
						size_word = shift_word;
						close_header(p);
					end
				end
				PH_FMT: take_fmt_byte(p - (64'(mark) - 64'(size_word)));
				default: ;
			endcase
			if (!last)
				return;
			if (seen < MIN_FILE)
				v.code = FLT_SHORT;
			else if (flt == FLT_RIFF || flt == FLT_WAVE)
				v.code = flt;
			else if (CntW'(declared_end) > seen)
				v.code = FLT_LENGTH;
			else if (flt != FLT_NONE)
				v.code = flt;
			else if (!fmt_good)
				v.code = FLT_FORMAT;
			else if (!data_good)
				v.code = FLT_DATA;
			else
				v.code = FLT_NONE;
			// header-level faults report no fmt fields
			early = v.code >= FLT_SHORT && v.code <= FLT_LENGTH;
			v.ok = v.code == FLT_NONE;
			v.chans = early ? '0 : fmt_chans;
			v.rate = early ? '0 : fmt_rate;
			v.bits = early ? '0 : fmt_bits;
			v.align = early ? '0 : fmt_align;
			verdicts_due = {verdicts_due, v};
			clear();
		endfunction

		function void field_check(longint unsigned now, string name,
			logic [WordW-1:0] want, logic [WordW-1:0] got);
			if (got !== want) begin
				errors++;
				$display("at %0d ns: %s expected %0d, got %0d", now, name, want, got);
			end
		endfunction

		function void check_verdict(longint unsigned now, logic ok, logic [3:0] code,
			logic [HalfW-1:0] chans, logic [WordW-1:0] rate,
			logic [HalfW-1:0] bits, logic [HalfW-1:0] align);
			verdict_t v;
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("at %0d ns: verdict with none pending, valid_res %0b fault %0d",
					now, ok, code);
				return;
			end
			v = verdicts_due.pop_front();
			field_check(now, "valid_res", v.ok, ok);
			field_check(now, "fault", v.code, code);
			field_check(now, "channels", v.chans, chans);
			field_check(now, "rate_hz", v.rate, rate);
			field_check(now, "bits_per_sample", v.bits, bits);
			field_check(now, "block_align", v.align, align);
		endfunction
	endclass

endpackage

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams RIFF/WAVE files byte by byte into the header validator: mostly
// well-formed files with random fmt fields and chunk layouts, plus corrupted
// tags, bad lengths, cut files, noise and oversized chunks. Every verdict is
// checked field by field against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rwhv_pkg::*;
	import wave_verdict_pkg::*;

	// file flavors
	localparam int unsigned FL_CLEAN      = 0;
	localparam int unsigned FL_BAD_RIFF   = 1;
	localparam int unsigned FL_BAD_WAVE   = 2;
	localparam int unsigned FL_LONG_DECL  = 3;
	localparam int unsigned FL_SHORT_DECL = 4;
	localparam int unsigned FL_TRAILER    = 5;
	localparam int unsigned FL_CUT        = 6;
	localparam int unsigned FL_NOISE      = 7;
	localparam int unsigned FL_JUMBLE     = 8;
	localparam int unsigned FL_HUGE       = 9;

	localparam int unsigned IDLE_PCT     = 31;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned RANDOM_BYTES = 1700;
	localparam int unsigned MIN_FILES    = 20;
	localparam int unsigned TAIL_CYCLES  = 64;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	logic [7:0]       data_byte;
	logic             last_byte;
	logic             result_valid;
	logic             result_stall;
	logic             valid_res;
	logic [3:0]       fault;
	logic [HalfW-1:0] channels;
	logic [WordW-1:0] rate_hz;
	logic [HalfW-1:0] bits_per_sample;
	logic [HalfW-1:0] block_align;

	wave_verdict_board board;
	logic [7:0]        file_bytes[$];
	logic [HalfW-1:0]  last_align;
	bit                size_blown;
	int unsigned       tx_idle = IDLE_PCT;
	int unsigned       rx_idle = IDLE_PCT;
	bit                hold_req = 1'b0;
	int unsigned       bytes_sent = 0;

	riff_wave_header_validator uut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#2_000_000;
		$display("riff_wave_header_validator: mismatch");
		$finish;
	end

	// result side: random stalls, plus one long hold when asked
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= $urandom_range(0, 99) < rx_idle;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_verdict($time, valid_res, fault, channels, rate_hz,
				bits_per_sample, block_align);
	end

	function automatic void put8(logic [7:0] b);
		file_bytes = {file_bytes, b};
	endfunction

	function automatic void put16(logic [15:0] w);
		put8(w[7:0]);
		put8(w[15:8]);
	endfunction

	function automatic void put32(logic [31:0] w);
		put16(w[15:0]);
		put16(w[31:16]);
	endfunction

	function automatic void put_junk(int unsigned n);
		repeat (n) put8(8'($urandom));
	endfunction

	// mostly the legal value, now and then a near miss or garbage
	function automatic logic [15:0] pick16(logic [15:0] good);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 94)
			return good;
		if (r < 97)
			return good + 16'd1;
		return 16'($urandom);
	endfunction

	function automatic void add_fmt();
		logic [15:0] tag, chans, bits, align;
		logic [31:0] rate, brate, size;
		tag = pick16(FMT_PCM);
		chans = pick16($urandom_range(0, 1) ? CH_STEREO : CH_MONO);
		bits = pick16($urandom_range(0, 1) ? BITS_16 : BITS_8);
		case ($urandom_range(0, 9))
			0: rate = RATE_MIN;
			1: rate = RATE_MAX;
			2: rate = $urandom_range(0, 1) ? RATE_MIN - 1 : RATE_MAX + 1;
			3: rate = $urandom;
			default: rate = $urandom_range(RATE_MIN, RATE_MAX);
		endcase
		align = pick16(16'(32'(chans) * 32'(bits) / 8));
		brate = ($urandom_range(0, 99) < 94) ? rate * 32'(align) : $urandom;
		case ($urandom_range(0, 19))
			0: size = $urandom_range(0, 15);
			1: size = 17;
			2: size = 18;
			3: size = $urandom_range(19, 30);
			default: size = FMT_MIN;
		endcase
		put32(TAG_FMT);
		put32(size);
		if (size < FMT_MIN)
			put_junk(size);
		else begin
			put16(tag);
			put16(chans);
			put32(rate);
			put32(brate);
			put16(align);
			put16(bits);
			put_junk(size - FMT_MIN);
			last_align = align;
		end
		if (size[0])
			put_junk(1);
	endfunction

	function automatic void add_data(bit blow);
		logic [31:0] size;
		int unsigned r;
		r = $urandom_range(0, 99);
		put32(TAG_DATA);
		if (blow || r < 3) begin
			// declared body far beyond anything sent
			put32({1'b1, 31'($urandom)});
			size_blown = 1'b1;
			return;
		end
		if (r < 10)
			size = 0;
		else if (r < 20 || last_align == 0 || last_align > 8)
			size = $urandom_range(1, 20);
		else
			size = 32'(last_align) * $urandom_range(1, 6);
		put32(size);
		put_junk(size);
		if (size[0])
			put_junk(1);
	endfunction

	function automatic void add_other();
		logic [31:0] id, size;
		id = $urandom;
		if (id == TAG_FMT || id == TAG_DATA)
			id[0] = ~id[0];
		size = $urandom_range(0, 9);
		put32(id);
		put32(size);
		put_junk(size);
		if (size[0])
			put_junk(1);
	endfunction

	function automatic void make_file(int unsigned flavor);
		logic [31:0] declared;
		int unsigned n, cut, idx;
		file_bytes.delete();
		last_align = '0;
		size_blown = 1'b0;
		if (flavor == FL_NOISE) begin
			put_junk($urandom_range(1, 80));
			return;
		end
		put32(TAG_RIFF);
		put32(32'd0);
		put32(TAG_WAVE);
		if (flavor == FL_JUMBLE) begin
			n = $urandom_range(1, 5);
			repeat (n) begin
				if (!size_blown) begin
					case ($urandom_range(0, 2))
						0: add_fmt();
						1: add_data(1'b0);
						default: add_other();
					endcase
				end
			end
		end else begin
			if ($urandom_range(0, 4) == 0)
				add_other();
			add_fmt();
			if ($urandom_range(0, 4) == 0)
				add_other();
			add_data(flavor == FL_HUGE);
		end
		declared = file_bytes.size() - 8;
		// a huge declared length lets the oversized chunk reach the size check
		if (size_blown && $urandom_range(0, 1))
			declared = 32'hFFFF_FFF0;
		case (flavor)
			FL_LONG_DECL: declared += $urandom_range(1, 6);
			FL_SHORT_DECL: declared -= $urandom_range(1, declared < 24 ? declared : 24);
			FL_TRAILER: put_junk($urandom_range(1, 12));
			default: ;
		endcase
		file_bytes[4] = declared[7:0];
		file_bytes[5] = declared[15:8];
		file_bytes[6] = declared[23:16];
		file_bytes[7] = declared[31:24];
		case (flavor)
			FL_BAD_RIFF: begin
				idx = $urandom_range(0, 3);
				file_bytes[idx] ^= 8'd1 << $urandom_range(0, 7);
			end
			FL_BAD_WAVE: begin
				idx = $urandom_range(8, 11);
				file_bytes[idx] ^= 8'd1 << $urandom_range(0, 7);
			end
			FL_CUT: begin
				cut = $urandom_range(1, file_bytes.size() < 47 ? file_bytes.size() : 47);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
			default: ;
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < tx_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do
			@(posedge clk);
		while (item_stall);
		board.take_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file();
		foreach (file_bytes[i])
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	initial begin
		int unsigned files, r, flavor;
		board = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one-byte file, then one file of each flavor
		file_bytes.delete();
		put8(8'hFF);
		send_file();
		for (int f = FL_CLEAN; f <= FL_HUGE; f++) begin
			make_file(f);
			send_file();
		end

		files = 0;
		while (bytes_sent < RANDOM_BYTES || files < MIN_FILES) begin
			// busy stretch on both sides; the result hold backs up the input
			if (files == 12) begin
				tx_idle = 0;
				rx_idle = 0;
				hold_req = 1'b1;
			end
			if (files == 16) begin
				tx_idle = IDLE_PCT;
				rx_idle = IDLE_PCT;
			end
			r = $urandom_range(0, 99);
			if (r < 60)
				flavor = FL_CLEAN;
			else if (r < 65)
				flavor = FL_BAD_RIFF;
			else if (r < 69)
				flavor = FL_BAD_WAVE;
			else if (r < 74)
				flavor = FL_LONG_DECL;
			else if (r < 79)
				flavor = FL_SHORT_DECL;
			else if (r < 84)
				flavor = FL_TRAILER;
			else if (r < 88)
				flavor = FL_CUT;
			else if (r < 92)
				flavor = FL_NOISE;
			else if (r < 97)
				flavor = FL_JUMBLE;
			else
				flavor = FL_HUGE;
			make_file(flavor);
			send_file();
			files++;
		end
		item_valid <= 1'b0;

		while (board.verdicts_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.verdicts_due.size() == 0)
			$display("riff_wave_header_validator: match");
		else
			$display("riff_wave_header_validator: mismatch");
		$finish;
	end

endmodule
